### rtl/core/lbc_pkg.sv
// Shared types and constants of the LRU block cache tag unit.
// Used by lbc_ctrl, lbc_datapath and lru_block_cache_tags_unit; depends on nothing.
package lbc_pkg;

	// Default geometry
	localparam int LBC_SLOTS      = 16;
	localparam int LBC_INDEX_BITS = 48;

	// Fixed field widths of the words on the ports
	localparam int FIELD_W      = 48;
	localparam int SLOT_FIELD_W = 4;

	// Request action codes
	localparam logic ACT_LOOKUP     = 1'b0;
	localparam logic ACT_INVALIDATE = 1'b1;

	typedef struct packed {
		logic               action;
		logic [FIELD_W-1:0] block_index;
		logic [3:0]         target_slot;
	} lbc_req_t;

	typedef struct packed {
		logic               hit;
		logic               rejected;
		logic [3:0]         slot;
		logic               load_needed;
		logic               evicted_valid;
		logic [FIELD_W-1:0] evicted_index;
	} lbc_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_UPDATE
	} lbc_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic match;
		logic commit;
	} lbc_cmd_t;

endpackage

### rtl/core/lbc_ctrl.sv
// Controller of the LRU block cache tag unit: request sequencing and response valid.
// Depends on lbc_pkg.
module lbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output lbc_pkg::lbc_cmd_t cmd
);
	import lbc_pkg::*;

	lbc_state_t state_q;
	lbc_state_t state_d;
	logic       rsp_valid_q;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		req_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MATCH;
				end
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
				state_d   = ST_UPDATE;
			end
			ST_UPDATE: begin
				// Hold until the response register is free
				if (!rsp_valid_q || !rsp_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Set on commit, drop once the word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

### rtl/core/lbc_datapath.sv
// Datapath of the LRU block cache tag unit: tags, valid bits, recency order, response register.
// Depends on lbc_pkg; driven by commands from lbc_ctrl.
module lbc_datapath #(
	parameter int CACHE_SLOTS = lbc_pkg::LBC_SLOTS,
	parameter int INDEX_BITS  = lbc_pkg::LBC_INDEX_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lbc_pkg::lbc_cmd_t           cmd,
	input  lbc_pkg::lbc_req_t           req,
	input  logic                        cfg_we,
	input  logic [lbc_pkg::FIELD_W-1:0] cfg_wdata,
	output lbc_pkg::lbc_rsp_t           rsp
);
	import lbc_pkg::*;

	localparam int TAG_W  = (INDEX_BITS < FIELD_W) ? INDEX_BITS : FIELD_W;
	localparam int SLOT_W = $clog2(CACHE_SLOTS);

	logic [FIELD_W-1:0] count_q;

	logic               act_s1;
	logic [TAG_W-1:0]   idx_s1;
	logic [3:0]         tgt_s1;

	logic [TAG_W-1:0]   tag_q   [CACHE_SLOTS];
	logic [CACHE_SLOTS-1:0] valid_q;
	logic [SLOT_W-1:0]  order_q [CACHE_SLOTS];

	logic [CACHE_SLOTS-1:0] hit_vec;
	logic [SLOT_W-1:0]  hit_slot;
	logic               hit_s2;
	logic [SLOT_W-1:0]  hit_slot_s2;
	logic               over_s2;

	logic [SLOT_W-1:0]  victim;
	logic [SLOT_W-1:0]  sel_slot;
	logic [SLOT_W-1:0]  pos;
	logic [SLOT_W-1:0]  order_d [CACHE_SLOTS];
	logic [SLOT_W-1:0]  tgt_slot;
	logic               tgt_ok;
	logic               do_insert;
	logic               do_touch;
	lbc_rsp_t           rsp_d;
	lbc_rsp_t           rsp_q;

	// Block count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Capture the request word, index cut to the compared width
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_s1 <= req.action;
			idx_s1 <= req.block_index[TAG_W-1:0];
			tgt_s1 <= req.target_slot;
		end
	end

	// Compare against every valid tag; lowest matching slot wins
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			hit_vec[i] = valid_q[i] && (tag_q[i] == idx_s1);
		end
		for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_slot = SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_s2      <= |hit_vec;
			hit_slot_s2 <= hit_slot;
			over_s2     <= (FIELD_W'(idx_s1) >= count_q);
		end
	end

	// Pick the slot to promote and find its position in the order
	assign victim   = order_q[0];
	assign sel_slot = hit_s2 ? hit_slot_s2 : victim;

	always_comb begin
		pos = '0;
		for (int i = 0; i < CACHE_SLOTS; i++) begin
			if (order_q[i] == sel_slot) begin
				pos = SLOT_W'(i);
			end
		end
	end

	// Shift the younger entries down and place the slot last
	always_comb begin
		for (int i = 0; i < CACHE_SLOTS - 1; i++) begin
			order_d[i] = (SLOT_W'(i) >= pos) ? order_q[i+1] : order_q[i];
		end
		order_d[CACHE_SLOTS-1] = sel_slot;
	end

	assign do_insert = (act_s1 == ACT_LOOKUP) && !hit_s2 && !over_s2;
	assign do_touch  = (act_s1 == ACT_LOOKUP) && (hit_s2 || !over_s2);
	assign tgt_slot  = SLOT_W'(tgt_s1);
	assign tgt_ok    = (7'(tgt_s1) < 7'(CACHE_SLOTS));

	// Valid bits and recency order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < CACHE_SLOTS; i++) begin
				order_q[i] <= SLOT_W'(i);
			end
		end else if (cmd.commit) begin
			if (do_touch) begin
				order_q <= order_d;
			end
			if (do_insert) begin
				valid_q[victim] <= 1'b1;
			end
			if ((act_s1 == ACT_INVALIDATE) && tgt_ok) begin
				valid_q[tgt_slot] <= 1'b0;
			end
		end
	end

	// Retag the victim on a miss that is not rejected
	always_ff @(posedge clk) begin
		if (cmd.commit && do_insert) begin
			tag_q[victim] <= idx_s1;
		end
	end

	// Form the response word
	always_comb begin
		rsp_d = '0;
		if (act_s1 == ACT_INVALIDATE) begin
			rsp_d.slot = tgt_s1;
		end else if (hit_s2) begin
			rsp_d.hit  = 1'b1;
			rsp_d.slot = SLOT_FIELD_W'(hit_slot_s2);
		end else if (over_s2) begin
			rsp_d.rejected = 1'b1;
		end else begin
			rsp_d.slot          = SLOT_FIELD_W'(victim);
			rsp_d.load_needed   = 1'b1;
			rsp_d.evicted_valid = valid_q[victim];
			if (valid_q[victim]) begin
				rsp_d.evicted_index = FIELD_W'(tag_q[victim]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

### rtl/core/lru_block_cache_tags_unit.sv
// Top level of the LRU block cache tag unit: controller plus datapath.
// Depends on lbc_pkg, lbc_ctrl and lbc_datapath.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries a lookup of a block
//   index or an invalidate of a slot. Response channel (rsp_valid / rsp_stall
//   / rsp) returns exactly one word per request, in request order.
//   cfg_we / cfg_wdata write the block count; write it only while idle.
// Timing:
//   A request is taken in the idle state, compared against all tags in the
//   next cycle and committed in the update state. A new request is taken
//   only after the previous one has committed.
//   The response sits in an output register, so the next request is taken
//   while a response still waits; commit waits while that register is full
//   and stalled, holding req_stall high.
// Reset:
//   arst_n clears valid bits, sets slot i at recency position i, zeroes the
//   block count and empties the response register.
module lru_block_cache_tags_unit #(
	parameter int CACHE_SLOTS = lbc_pkg::LBC_SLOTS,
	parameter int INDEX_BITS  = lbc_pkg::LBC_INDEX_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  lbc_pkg::lbc_req_t           req,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output lbc_pkg::lbc_rsp_t           rsp,
	input  logic                        cfg_we,
	input  logic [lbc_pkg::FIELD_W-1:0] cfg_wdata
);
	import lbc_pkg::*;

	lbc_cmd_t cmd;

	lbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	lbc_datapath #(
		.CACHE_SLOTS (CACHE_SLOTS),
		.INDEX_BITS  (INDEX_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp       (rsp)
	);

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for lru_block_cache_tags_unit: LRU tag lookups, evictions,
// rejects and invalidates checked against a cycle-free tag and recency predictor.
// Depends on lbc_pkg and the RTL of lru_block_cache_tags_unit.
module tb;
	import lbc_pkg::*;

	localparam int  CYCLE_LIMIT = 200000;
	localparam int  SLOTS       = 16;
	localparam int  HOLD_CYCLES = 200;
	localparam int  HOLD_AT     = 100;

	// Tag store, recency order and block count as the block should hold them
	class lru_tag_predictor;
		logic [FIELD_W-1:0] tag [SLOTS];
		bit                 valid_mark [SLOTS];
		logic [3:0]         order [SLOTS];
		logic [FIELD_W-1:0] block_count;
		lbc_rsp_t           rsp_due_q [$];
		int                 errors;
		int                 taken;

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				tag[i] = '0;
				valid_mark[i] = 1'b0;
				order[i] = 4'(i);
			end
			block_count = '0;
			errors = 0;
			taken = 0;
		endfunction

		function void set_count(logic [FIELD_W-1:0] v);
			block_count = v;
		endfunction

		function int pending();
			return rsp_due_q.size();
		endfunction

		// Move slot s to the most recent position, keep the rest in order
		function void promote(logic [3:0] s);
			int p;
			p = 0;
			while (order[p] != s)
				p++;
			for (int i = p; i < SLOTS - 1; i++)
				order[i] = order[i + 1];
			order[SLOTS - 1] = s;
		endfunction

		// Work out the response word of one accepted request and queue it
		function void predict_request(lbc_req_t w);
			lbc_rsp_t   e;
			int         hit_slot;
			logic [3:0] victim;
			e = '0;
			hit_slot = -1;
			if (w.action == ACT_INVALIDATE) begin
				e.slot = w.target_slot;
				valid_mark[w.target_slot] = 1'b0;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (hit_slot < 0 && valid_mark[i] && tag[i] == w.block_index)
						hit_slot = i;
				if (hit_slot >= 0) begin
					promote(4'(hit_slot));
					e.hit = 1'b1;
					e.slot = 4'(hit_slot);
				end else if (w.block_index >= block_count) begin
					e.rejected = 1'b1;
				end else begin
					victim = order[0];
					if (valid_mark[victim]) begin
						e.evicted_valid = 1'b1;
						e.evicted_index = tag[victim];
					end
					tag[victim] = w.block_index;
					valid_mark[victim] = 1'b1;
					promote(victim);
					e.slot = victim;
					e.load_needed = 1'b1;
				end
			end
			rsp_due_q.push_back(e);
			taken++;
		endfunction

		function void check_field(string name, logic [FIELD_W-1:0] exp_v,
				logic [FIELD_W-1:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Compare one accepted response word with the oldest prediction
		function void check_response(lbc_rsp_t got);
			lbc_rsp_t e;
			if (rsp_due_q.size() == 0) begin
				$error("response word 0x%0h with no request waiting", got);
				errors++;
				return;
			end
			e = rsp_due_q.pop_front();
			check_field("hit", FIELD_W'(e.hit), FIELD_W'(got.hit));
			check_field("rejected", FIELD_W'(e.rejected), FIELD_W'(got.rejected));
			check_field("slot", FIELD_W'(e.slot), FIELD_W'(got.slot));
			check_field("load_needed", FIELD_W'(e.load_needed), FIELD_W'(got.load_needed));
			check_field("evicted_valid", FIELD_W'(e.evicted_valid),
				FIELD_W'(got.evicted_valid));
			check_field("evicted_index", e.evicted_index, got.evicted_index);
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               req_valid;
	logic               req_stall;
	lbc_req_t           req;
	logic               rsp_valid;
	logic               rsp_stall;
	lbc_rsp_t           rsp;
	logic               cfg_we;
	logic [FIELD_W-1:0] cfg_wdata;

	lru_tag_predictor   pred;
	bit                 no_idle;
	int                 cycle_count;

	lru_block_cache_tags_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	// Check every response word taken at a rising edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			pred.check_response(rsp);
	end

	// Drive the response stall: random idling, plus one long hold-off
	initial begin
		int  hold_left;
		bit  hold_done;
		rsp_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever @(negedge clk) begin
			if (!hold_done && pred.taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= !no_idle && ($urandom_range(99) < 14);
			end
		end
	end

	function automatic lbc_req_t build_word(logic act, logic [FIELD_W-1:0] idx,
			logic [3:0] target);
		lbc_req_t w;
		w.action = act;
		w.block_index = idx;
		w.target_slot = target;
		return w;
	endfunction

	function automatic logic [FIELD_W-1:0] rand_index();
		return FIELD_W'({$urandom, $urandom});
	endfunction

	// Offer one request word, hold it until taken, then record it
	task automatic send_word(lbc_req_t w);
		@(negedge clk);
		if (!no_idle && $urandom_range(99) < 14) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do
			@(posedge clk);
		while (req_stall);
		pred.predict_request(w);
	endtask

	// Drop valid and wait until every predicted word has come back
	task automatic settle();
		@(negedge clk) req_valid <= 1'b0;
		while (pred.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_block_count(logic [FIELD_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk) pred.set_count(v);
		@(negedge clk) cfg_we <= 1'b0;
	endtask

	// Pick an index: mostly a small reused range so hits and evictions recur,
	// some at the count boundary, some across the full width
	function automatic logic [FIELD_W-1:0] pick_index(logic [FIELD_W-1:0] count);
		int                 s;
		int                 bound;
		s = $urandom_range(99);
		bound = (count < FIELD_W'(34)) ? int'(count) + 6 : 40;
		if (s < 70)
			return FIELD_W'($urandom_range(0, bound));
		else if (s < 85)
			return count + FIELD_W'($urandom_range(0, 2)) - FIELD_W'(1);
		else
			return rand_index();
	endfunction

	task automatic random_phase(logic [FIELD_W-1:0] count, int n);
		lbc_req_t w;
		write_block_count(count);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 12)
				w = build_word(ACT_INVALIDATE, rand_index(), 4'($urandom_range(0, 15)));
			else
				w = build_word(ACT_LOOKUP, pick_index(count), 4'($urandom_range(0, 15)));
			send_word(w);
		end
		settle();
	endtask

	initial begin
		pred = new();
		clk = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		no_idle = 1'b0;
		cycle_count = 0;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Count zero after reset: every lookup misses and is rejected
		send_word(build_word(ACT_LOOKUP, '0, 4'hF));
		send_word(build_word(ACT_LOOKUP, '1, 4'h0));
		send_word(build_word(ACT_INVALIDATE, '0, 4'h0));
		settle();

		// Full count: fill all slots, evict the oldest, hit, invalidate
		write_block_count('1);
		send_word(build_word(ACT_LOOKUP, '0, 4'h0));
		send_word(build_word(ACT_LOOKUP, 48'hFFFF_FFFF_FFFE, 4'h0));
		send_word(build_word(ACT_LOOKUP, 48'hAAAA_AAAA_AAAA, 4'h0));
		send_word(build_word(ACT_LOOKUP, 48'h5555_5555_5555, 4'h0));
		for (int i = 1; i <= 12; i++)
			send_word(build_word(ACT_LOOKUP, FIELD_W'(i), 4'h0));
		send_word(build_word(ACT_LOOKUP, 48'h8000_0000_0000, 4'h0));
		send_word(build_word(ACT_LOOKUP, 48'hAAAA_AAAA_AAAA, 4'h0));
		send_word(build_word(ACT_INVALIDATE, '0, 4'hF));
		send_word(build_word(ACT_INVALIDATE, '1, 4'hF));
		send_word(build_word(ACT_LOOKUP, '1, 4'h0));
		send_word(build_word(ACT_LOOKUP, FIELD_W'(12), 4'h0));
		settle();

		// Random phases over several block counts, one without idling
		random_phase(FIELD_W'(24), 90);
		random_phase('0, 20);
		random_phase(FIELD_W'(1), 30);
		no_idle = 1'b1;
		random_phase(FIELD_W'(40), 90);
		no_idle = 1'b0;
		random_phase('1, 90);
		random_phase(FIELD_W'(20), 80);

		if (pred.errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end
endmodule

### lru_block_cache_tags_unit.f
rtl/core/lbc_pkg.sv
rtl/core/lbc_ctrl.sv
rtl/core/lbc_datapath.sv
rtl/core/lru_block_cache_tags_unit.sv
tb/tb.sv
